>>> src/csvfs_pkg.sv
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared constants and helpers for the CSV field splitter.
// ----------------------------------------------------------------------------
package csvfs_pkg;

  // Result kinds carried in the low bits of the master-side tuser.
  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_LINE_END  = 2'd2;

  // Request opcodes carried in the slave-side tuser.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOL  = 1'b1;

  localparam logic [7:0] QUOTE_BYTE = 8'h22;
  localparam logic [7:0] COMMA_BYTE = 8'h2C;

  // Space, or one of the control characters tab through carriage return.
  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

endpackage

>>> src/csv_field_splitter_top.sv
// ----------------------------------------------------------------------------
// csv_field_splitter_top
// Splits a byte stream of one text line into trimmed comma-separated fields.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one request per line byte (tuser = 0, byte in
// tdata) and a closing end-of-line request (tuser = 1). The master channel
// returns the field bytes, each field followed by a field-end result; tuser[1:0]
// gives the kind and tuser[2] the whitespace-overflow flag, and tlast marks
// the last result produced by a given request.
// The first result of an accepted request is held in the output register
// from the next cycle on, except for a data byte that releases held bytes.
// Quote, leading-space and held-space requests give no result. A data byte
// that follows N held whitespace bytes is parked while the block starts the
// first read of the pending-whitespace RAM, sends the held bytes one per
// cycle while the receiver takes them (its single read port sets the pace)
// and then sends the byte itself; tready stays low until it is loaded.
// Every other request is taken back to back.
// After reset the block is outside any quote and any field; no clearing pass
// is needed since only entries written within the current field are read.
// When the receiver stalls, the output register holds its result and the
// slave tready drops until that result is taken; the drain pauses likewise.
// ----------------------------------------------------------------------------
module csv_field_splitter_top #(
  parameter int PENDING_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Request channel.
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] byte_req
  input  logic       s_axis_tuser_i,  // [0] op
  // Result channel.
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] data_byte
  output logic [2:0] m_axis_tuser_o,  // [1:0] kind, [2] overflow
  output logic       m_axis_tlast_o
);
  import csvfs_pkg::*;

  // Address width of the whitespace RAM and width of the fill count, which
  // must also hold the full depth.
  localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CW = $clog2(PENDING_DEPTH + 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  // Pending trailing-whitespace store.
  logic [7:0] pend_mem [PENDING_DEPTH];

  logic          state_q, state_d;
  logic          quoted_q, quoted_d;
  logic          started_q, started_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic          rd_vld_q, rd_vld_d;
  logic [7:0]    rdata_q;
  logic [7:0]    held_q;

  logic          out_valid_q;
  logic [1:0]    out_kind_q;
  logic [7:0]    out_data_q;
  logic          out_ovf_q;
  logic          out_last_q;

  logic          out_free;
  logic          in_acc;
  logic          load;
  logic [1:0]    load_kind;
  logic [7:0]    load_data;
  logic          load_ovf;
  logic          load_last;
  logic          wr_en;
  logic          rd_en;
  logic          hold_byte;
  logic          consume;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign consume         = (state_q == ST_DRAIN) && rd_vld_q && out_free;

  always_comb begin
    state_d   = state_q;
    quoted_d  = quoted_q;
    started_d = started_q;
    ovf_d     = ovf_q;
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    rd_vld_d  = rd_vld_q;
    load      = 1'b0;
    load_kind = KIND_DATA;
    load_data = 8'd0;
    load_ovf  = 1'b0;
    load_last = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    hold_byte = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i == OP_EOL) begin
            load      = 1'b1;
            load_kind = KIND_LINE_END;
            load_ovf  = ovf_q;
            load_last = 1'b1;
            count_d   = '0;
            started_d = 1'b0;
            ovf_d     = 1'b0;
            quoted_d  = 1'b0;
          end else if (s_axis_tdata_i == QUOTE_BYTE) begin
            quoted_d = !quoted_q;
          end else if ((s_axis_tdata_i == COMMA_BYTE) && !quoted_q) begin
            load      = 1'b1;
            load_kind = KIND_FIELD_END;
            load_ovf  = ovf_q;
            load_last = 1'b1;
            count_d   = '0;
            started_d = 1'b0;
            ovf_d     = 1'b0;
          end else if (is_blank(s_axis_tdata_i)) begin
            if (started_q) begin
              if (count_q < CW'(PENDING_DEPTH)) begin
                wr_en   = 1'b1;
                count_d = count_q + CW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
          end else if (count_q == '0) begin
            load      = 1'b1;
            load_data = s_axis_tdata_i;
            load_last = 1'b1;
            started_d = 1'b1;
          end else begin
            // Held whitespace must go out first; park the byte.
            hold_byte = 1'b1;
            rd_idx_d  = '0;
            rd_vld_d  = 1'b0;
            state_d   = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (consume) begin
          load      = 1'b1;
          load_data = rdata_q;
        end
        rd_en    = (rd_idx_q != count_q) && (!rd_vld_q || consume);
        rd_vld_d = rd_en || (rd_vld_q && !consume);
        if (rd_en) begin
          rd_idx_d = rd_idx_q + CW'(1);
        end
        if ((rd_idx_q == count_q) && !rd_vld_q && out_free) begin
          load      = 1'b1;
          load_data = held_q;
          load_last = 1'b1;
          started_d = 1'b1;
          count_d   = '0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      quoted_q    <= 1'b0;
      started_q   <= 1'b0;
      ovf_q       <= 1'b0;
      count_q     <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      quoted_q  <= quoted_d;
      started_q <= started_d;
      ovf_q     <= ovf_d;
      count_q   <= count_d;
      rd_idx_q  <= rd_idx_d;
      rd_vld_q  <= rd_vld_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q <= load_kind;
      out_data_q <= load_data;
      out_ovf_q  <= load_ovf;
      out_last_q <= load_last;
    end
    if (hold_byte) begin
      held_q <= s_axis_tdata_i;
    end
  end

  // Whitespace RAM: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pend_mem[count_q[AW-1:0]] <= s_axis_tdata_i;
    end
    if (rd_en) begin
      rdata_q <= pend_mem[rd_idx_q[AW-1:0]];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = {out_ovf_q, out_kind_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule
